// File: rtl/core/lwfs_pkg.sv
`timescale 1ns / 1ps
package lwfs_pkg;

  // opcodes of the input item
  localparam logic [1:0] OP_WINDOW = 2'd0;
  localparam logic [1:0] OP_PIXEL  = 2'd1;
  localparam logic [1:0] OP_FILL   = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  // controller commands
  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_PAGE_SET     = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  localparam int CoordW = 10;
  localparam int CountW = 17;
  localparam int ColorW = 16;
  localparam int StepW  = 6;

  localparam logic [CountW-1:0] COUNT_MAX = '1;

  // window command sequence ends on this step (memory write)
  localparam logic [StepW-1:0] WINDOW_LAST_STEP = 6'd10;

  typedef enum logic {
    KIND_WINDOW,
    KIND_PIXEL
  } kind_e;

  // one classified job handed from the front to the back
  typedef struct packed {
    kind_e              kind;
    logic [CoordW-1:0]  c0;
    logic [CoordW-1:0]  c1;
    logic [CoordW-1:0]  r0;
    logic [CoordW-1:0]  r1;
    logic [CountW-1:0]  count;
    logic [ColorW-1:0]  color;
    logic [StepW-1:0]   last_step;
    logic               fill_active;
  } job_t;

  // 8-bit rgb to rgb565
  function automatic logic [ColorW-1:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// File: rtl/core/lwfs_front.sv
`timescale 1ns / 1ps
module lwfs_front
  import lwfs_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 320,
  parameter int MAX_REPEAT    = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [CoordW-1:0] x_a_i,
  input  logic [CoordW-1:0] y_a_i,
  input  logic [CoordW-1:0] x_b_i,
  input  logic [CoordW-1:0] y_b_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  input  logic [5:0]        repeat_req_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output job_t              push_job_o
);

  localparam logic [CoordW-1:0] XLast  = CoordW'(SCREEN_WIDTH - 1);
  localparam logic [CoordW-1:0] YLast  = CoordW'(SCREEN_HEIGHT - 1);
  localparam logic [5:0]        RepMax = 6'(MAX_REPEAT);

  logic [CoordW-1:0] xmin, xmax, ymin, ymax;
  logic [5:0]        rep_sat;

  logic              s1_valid_q;
  logic [1:0]        s1_op_q;
  logic [CoordW-1:0] c0_q, c1_q, r0_q, r1_q;
  logic [ColorW-1:0] color_q;
  logic [5:0]        rep_q;

  logic [CountW-1:0] fill_rem_q, fill_rem_d;
  logic [ColorW-1:0] fill_color_q, fill_color_d;

  logic [CoordW-1:0]   dx, dy;
  logic [2*CoordW-1:0] prod;
  logic [CountW-1:0]   count;
  logic                emits;
  logic                fire;

  // sort corners and clip to the screen
  always_comb begin
    xmin = (x_a_i < x_b_i) ? x_a_i : x_b_i;
    xmax = (x_a_i < x_b_i) ? x_b_i : x_a_i;
    ymin = (y_a_i < y_b_i) ? y_a_i : y_b_i;
    ymax = (y_a_i < y_b_i) ? y_b_i : y_a_i;
    if (xmin > XLast) xmin = XLast;
    if (xmax > XLast) xmax = XLast;
    if (ymin > YLast) ymin = YLast;
    if (ymax > YLast) ymax = YLast;
    rep_sat = (repeat_req_i > RepMax) ? RepMax : repeat_req_i;
  end

  assign in_ready_o = !s1_valid_q || fire;

  // classify stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_op_q <= opcode_i;
      c0_q    <= xmin;
      c1_q    <= xmax;
      r0_q    <= ymin;
      r1_q    <= ymax;
      color_q <= pack565(red_i, green_i, blue_i);
      rep_q   <= rep_sat;
    end
  end

  // window pixel count, saturated
  always_comb begin
    dx    = c1_q - c0_q + 10'd1;
    dy    = r1_q - r0_q + 10'd1;
    prod  = {{CoordW{1'b0}}, dx} * {{CoordW{1'b0}}, dy};
    count = (prod > {3'd0, COUNT_MAX}) ? COUNT_MAX : prod[CountW-1:0];
  end

  // fill state update and job build
  always_comb begin
    fill_rem_d   = fill_rem_q;
    fill_color_d = fill_color_q;
    emits        = 1'b1;
    push_job_o   = '0;
    case (s1_op_q)
      OP_WINDOW: begin
        fill_rem_d = '0;
      end
      OP_FILL: begin
        fill_rem_d   = count;
        fill_color_d = color_q;
      end
      OP_PIXEL: begin
        emits = (rep_q != 6'd0);
      end
      OP_TICK: begin
        emits = (fill_rem_q != '0);
        if (emits) fill_rem_d = fill_rem_q - 17'd1;
      end
      default: begin
        emits = 1'b0;
      end
    endcase

    push_job_o.c0          = c0_q;
    push_job_o.c1          = c1_q;
    push_job_o.r0          = r0_q;
    push_job_o.r1          = r1_q;
    push_job_o.fill_active = (fill_rem_d != '0);
    if (s1_op_q == OP_WINDOW || s1_op_q == OP_FILL) begin
      push_job_o.kind      = KIND_WINDOW;
      push_job_o.count     = count;
      push_job_o.last_step = WINDOW_LAST_STEP;
    end else if (s1_op_q == OP_PIXEL) begin
      push_job_o.kind      = KIND_PIXEL;
      push_job_o.color     = color_q;
      push_job_o.last_step = {5'(rep_q - 6'd1), 1'b1};
    end else begin
      push_job_o.kind      = KIND_PIXEL;
      push_job_o.color     = fill_color_q;
      push_job_o.last_step = 6'd1;
    end
  end

  assign push_valid_o = s1_valid_q && emits;
  assign fire         = s1_valid_q && (!emits || push_ready_i);

  // fill state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_rem_q   <= '0;
      fill_color_q <= '0;
    end else if (fire) begin
      fill_rem_q   <= fill_rem_d;
      fill_color_q <= fill_color_d;
    end
  end

endmodule

// File: rtl/core/lwfs_queue.sv
`timescale 1ns / 1ps
module lwfs_queue
  import lwfs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_i,
  output job_t pop_job_o
);

  job_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       do_push, do_pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_job_o    = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= push_job_i;
  end

  // pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

// File: rtl/core/lwfs_back.sv
`timescale 1ns / 1ps
module lwfs_back
  import lwfs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  job_t              job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              dnc_o,
  output logic [7:0]        byte_o,
  output logic              last_o,
  output logic [CountW-1:0] pixels_o,
  output logic              fill_active_o
);

  logic [StepW-1:0]  step_q;
  logic              out_valid_q;
  logic              dnc_q, last_q, fill_act_q;
  logic [7:0]        byte_q;
  logic [CountW-1:0] pixels_q;

  logic       advance, is_last;
  logic       dnc_d;
  logic [7:0] byte_d;

  assign advance = job_valid_i && (!out_valid_q || out_ready_i);
  assign is_last = (step_q == job_i.last_step);
  assign pop_o   = advance && is_last;

  // byte selection for the current step
  always_comb begin
    dnc_d  = 1'b1;
    byte_d = '0;
    if (job_i.kind == KIND_PIXEL) begin
      byte_d = step_q[0] ? job_i.color[7:0] : job_i.color[15:8];
    end else begin
      case (step_q)
        6'd0: begin
          dnc_d  = 1'b0;
          byte_d = CMD_COLUMN_SET;
        end
        6'd1: byte_d = {6'd0, job_i.c0[9:8]};
        6'd2: byte_d = job_i.c0[7:0];
        6'd3: byte_d = {6'd0, job_i.c1[9:8]};
        6'd4: byte_d = job_i.c1[7:0];
        6'd5: begin
          dnc_d  = 1'b0;
          byte_d = CMD_PAGE_SET;
        end
        6'd6: byte_d = {6'd0, job_i.r0[9:8]};
        6'd7: byte_d = job_i.r0[7:0];
        6'd8: byte_d = {6'd0, job_i.r1[9:8]};
        6'd9: byte_d = job_i.r1[7:0];
        default: begin
          dnc_d  = 1'b0;
          byte_d = CMD_MEMORY_WRITE;
        end
      endcase
    end
  end

  // step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        step_q <= is_last ? '0 : step_q + 6'd1;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      dnc_q      <= dnc_d;
      byte_q     <= byte_d;
      last_q     <= is_last;
      pixels_q   <= (is_last && job_i.kind == KIND_WINDOW) ? job_i.count : '0;
      fill_act_q <= job_i.fill_active;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign dnc_o         = dnc_q;
  assign byte_o        = byte_q;
  assign last_o        = last_q;
  assign pixels_o      = pixels_q;
  assign fill_active_o = fill_act_q;

endmodule

// File: rtl/core/lcd_window_fill_sequencer.sv
`timescale 1ns / 1ps
// Display bus sequencer: each input item (window, pixel, fill or tick) turns into a
// run of bus writes, one write per clock from the back-end output register when not
// stalled. A window or fill item gives 11 writes (column set, page set, memory write with
// the pixel count on the last write), a pixel item 2 * repeat writes (repeat capped at
// MAX_REPEAT, zero gives no writes), and a tick 2 writes while fill pixels remain, none
// otherwise. The write rate of the back end sets the throughput; the front end takes one
// item per cycle, when not stalled, into a two-entry job queue, so a new item is accepted
// while earlier writes are still going out. Corners are sorted and clipped to the screen
// before the count is formed; a window cancels a pending fill, a fill replaces it.
module lcd_window_fill_sequencer
  import lwfs_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 320,
  parameter int MAX_REPEAT    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // x_a[9:0], y_a[19:10], x_b[29:20], y_b[39:30], red[47:40], green[55:48],
  // blue[63:56], repeat_req[69:64], zero pad[71:70]
  input  logic [71:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // bus_byte[7:0], pixels_expected[24:8], fill_active[25], zero pad[31:26]
  output logic [31:0] m_axis_tdata,
  // data_not_command[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  logic              push_valid, push_ready;
  job_t              push_job;
  logic              job_valid, pop;
  job_t              job_head;
  logic [7:0]        bus_byte;
  logic [CountW-1:0] pixels;
  logic              fill_active;

  // classify and track fill state
  lwfs_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .MAX_REPEAT   (MAX_REPEAT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (s_axis_tuser),
    .x_a_i       (s_axis_tdata[9:0]),
    .y_a_i       (s_axis_tdata[19:10]),
    .x_b_i       (s_axis_tdata[29:20]),
    .y_b_i       (s_axis_tdata[39:30]),
    .red_i       (s_axis_tdata[47:40]),
    .green_i     (s_axis_tdata[55:48]),
    .blue_i      (s_axis_tdata[63:56]),
    .repeat_req_i(s_axis_tdata[69:64]),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_job_o  (push_job)
  );

  // job queue between front and back
  lwfs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_job_i  (push_job),
    .pop_valid_o (job_valid),
    .pop_i       (pop),
    .pop_job_o   (job_head)
  );

  // bus write generation
  lwfs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_i        (job_head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .dnc_o        (m_axis_tuser),
    .byte_o       (bus_byte),
    .last_o       (m_axis_tlast),
    .pixels_o     (pixels),
    .fill_active_o(fill_active)
  );

  assign m_axis_tdata = {6'd0, fill_active, pixels, bus_byte};

`ifndef SYNTHESIS
  // a stalled job in the front blocks new items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid && !push_ready |-> !s_axis_tready)
    else $error("front accepts while its job is stalled");

  // the only command that ends a run is memory write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && !m_axis_tuser |-> m_axis_tdata[7:0] == CMD_MEMORY_WRITE)
    else $error("command run ends on a wrong command");

  // pixel count shows only on the closing memory write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[24:8] != 17'd0 |-> m_axis_tlast && !m_axis_tuser)
    else $error("pixel count outside the closing write");
`endif

endmodule
